@@ hw/rtl/rrp_pkg.sv @@
// rrp_pkg: shared types and constants for the row record parser.
// Holds the result kind codes, field widths and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package rrp_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned LenW       = 16;
  localparam int unsigned NameLimW   = 5;
  localparam int unsigned EmailLimW  = 8;
  localparam int unsigned CfgIndexW  = 8;
  localparam int unsigned CfgDataW   = 8;

  // Register indexes on the configuration port
  localparam logic [CfgIndexW-1:0] CFG_NAME_LIMIT  = 8'd0;
  localparam logic [CfgIndexW-1:0] CFG_EMAIL_LIMIT = 8'd1;

  // Register reset values
  localparam logic [NameLimW-1:0]  NAME_LIMIT_RST  = 5'd31;
  localparam logic [EmailLimW-1:0] EMAIL_LIMIT_RST = 8'd254;

  // Result kind codes
  typedef enum logic [2:0] {
    KIND_ABSORB = 3'd0,
    KIND_ID     = 3'd1,
    KIND_NLEN   = 3'd2,
    KIND_NBYTE  = 3'd3,
    KIND_ELEN   = 3'd4,
    KIND_EBYTE  = 3'd5
  } kind_t;

endpackage

@@ hw/rtl/row_record_parser_top.sv @@
// row_record_parser_top: byte-serial parser for serialized row records.
// Depends on rrp_pkg for kind codes, widths and register indexes.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-----------------------------------
//   input    | in        | in_valid / in_stall  | byte_in
//   result   | out       | out_valid / out_stall| kind, value, record_end, length_error
//   config   | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One byte per clock unless stalled: a byte is parsed in the cycle it is
// accepted and its word appears in the result register on the next cycle. The
// single result register sets throughput and reloads in the same cycle it is
// taken. in_stall rises only while a result is held and out_stall is high.
// rst is synchronous: parse state returns to the id phase, limits to 31 and 254.
// cfg_ready is always high; writes beyond the register list are dropped.
`timescale 1ns / 1ps

module row_record_parser_top
  import rrp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // byte input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ByteW-1:0]      byte_in,
  // result output
  output logic                  out_valid,
  input  logic                  out_stall,
  output kind_t                 kind,
  output logic [ValueW-1:0]     value,
  output logic                  record_end,
  output logic                  length_error,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CfgIndexW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0]   cfg_data
);

  typedef enum logic [2:0] {
    PH_ID    = 3'd0,
    PH_NLEN  = 3'd1,
    PH_NAME  = 3'd2,
    PH_ELEN  = 3'd3,
    PH_EMAIL = 3'd4
  } phase_t;

  // Parse state and limits
  phase_t                phase, phase_next;
  logic [ByteW-1:0]      byte_count, byte_count_next;
  logic [ValueW-1:0]     id_accum, id_accum_next;
  logic [ByteW-1:0]      length_accum, length_accum_next;
  logic [NameLimW-1:0]   name_limit;
  logic [EmailLimW-1:0]  email_limit;

  // Result word for the byte being accepted
  kind_t                 res_kind;
  logic [ValueW-1:0]     res_value;
  logic                  res_end;
  logic                  res_err;

  logic                  in_accept;
  logic [LenW-1:0]       len;
  logic [ByteW-1:0]      count_inc;
  logic [ValueW-1:0]     id_merged;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  assign len       = {byte_in, length_accum};
  assign count_inc = byte_count + 8'd1;
  assign id_merged = id_accum |
                     (ValueW'(byte_in) << {byte_count[1:0], 3'b000});

  // Next state and result for one byte
  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    id_accum_next     = id_accum;
    length_accum_next = length_accum;
    res_kind          = KIND_ABSORB;
    res_value         = '0;
    res_end           = 1'b0;
    res_err           = 1'b0;

    unique case (phase) inside
      PH_NLEN, PH_ELEN: begin
        if (byte_count == '0) begin
          // low length byte
          length_accum_next = byte_in;
          byte_count_next   = 8'd1;
        end else begin
          res_kind  = (phase == PH_NLEN) ? KIND_NLEN : KIND_ELEN;
          res_value = ValueW'(len);
          if ((phase == PH_NLEN && len > LenW'(name_limit)) ||
              (phase == PH_ELEN && len > LenW'(email_limit))) begin
            // over limit: abandon record
            res_err           = 1'b1;
            phase_next        = PH_ID;
            byte_count_next   = '0;
            id_accum_next     = '0;
            length_accum_next = '0;
          end else if (phase == PH_ELEN && len == '0) begin
            // empty email closes the record
            res_end           = 1'b1;
            phase_next        = PH_ID;
            byte_count_next   = '0;
            id_accum_next     = '0;
            length_accum_next = '0;
          end else begin
            // accepted length fits in a byte
            length_accum_next = len[ByteW-1:0];
            byte_count_next   = '0;
            if (phase == PH_ELEN) begin
              phase_next = PH_EMAIL;
            end else begin
              phase_next = (len == '0) ? PH_ELEN : PH_NAME;
            end
          end
        end
      end

      PH_NAME: begin
        res_kind  = KIND_NBYTE;
        res_value = ValueW'(byte_in);
        if (count_inc >= length_accum) begin
          phase_next        = PH_ELEN;
          byte_count_next   = '0;
          length_accum_next = '0;
        end else begin
          byte_count_next = count_inc;
        end
      end

      PH_EMAIL: begin
        res_kind  = KIND_EBYTE;
        res_value = ValueW'(byte_in);
        if (count_inc >= length_accum) begin
          res_end           = 1'b1;
          phase_next        = PH_ID;
          byte_count_next   = '0;
          id_accum_next     = '0;
          length_accum_next = '0;
        end else begin
          byte_count_next = count_inc;
        end
      end

      default: begin
        // id bytes, little-endian
        phase_next    = PH_ID;
        id_accum_next = id_merged;
        if (byte_count >= 8'd3) begin
          res_kind          = KIND_ID;
          res_value         = id_merged;
          phase_next        = PH_NLEN;
          byte_count_next   = '0;
          length_accum_next = '0;
        end else begin
          byte_count_next = count_inc;
        end
      end
    endcase
  end

  // State, limits and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_ID;
      byte_count   <= '0;
      id_accum     <= '0;
      length_accum <= '0;
      name_limit   <= NAME_LIMIT_RST;
      email_limit  <= EMAIL_LIMIT_RST;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_NAME_LIMIT:  name_limit  <= cfg_data[NameLimW-1:0];
          CFG_EMAIL_LIMIT: email_limit <= cfg_data[EmailLimW-1:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        phase        <= phase_next;
        byte_count   <= byte_count_next;
        id_accum     <= id_accum_next;
        length_accum <= length_accum_next;
        out_valid    <= 1'b1;
        // payload is loaded with each accepted byte
        kind         <= res_kind;
        value        <= res_value;
        record_end   <= res_end;
        length_error <= res_err;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Checks
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted byte produced no result");

  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && length_error) |-> ((kind == KIND_NLEN || kind == KIND_ELEN) && !record_end))
    else $error("length error on a non-length word");

  a_end_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && record_end) |-> (kind == KIND_ELEN || kind == KIND_EBYTE))
    else $error("record end on a word that cannot close a record");

  a_absorb_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_ABSORB) |-> (value == '0))
    else $error("absorbed header byte with nonzero value");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (res_end || res_err)) |=> (phase == PH_ID && byte_count == '0))
    else $error("parser did not return to the id phase");

endmodule
